>>> rtl/assert_macros.svh
// Assertion macros shared by the transcoder RTL.
// No dependencies; included by the modules that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge while reset is released.
`define ASSERT_CLK(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
		else $error("assertion failed");

// Condition that must never be true while reset is released.
`define ASSERT_NEVER(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) \
		else $error("forbidden condition seen");

`endif

>>> rtl/gbbt_pkg.sv
// Shared types, constants and byte classification functions of the
// GB2312 / Big5 transcoder. No dependencies.
`default_nettype none

package gbbt_pkg;

	// Default number of words in the code table.
	localparam int unsigned TABLE_WORDS_DEF = 32768;

	// Configuration port.
	localparam int unsigned CFG_DATA_W = 15;
	localparam logic [0:0] REG_DIRECTION    = 1'b0;
	localparam logic [0:0] REG_GB_ROWS_BASE = 1'b1;
	localparam logic [14:0] GB_ROWS_BASE_RST = 15'd13973;

	// Direction codes.
	localparam logic DIR_GB_TO_BIG5 = 1'b0;
	localparam logic DIR_BIG5_TO_GB = 1'b1;

	// Request types.
	localparam logic REQ_LOAD   = 1'b0;
	localparam logic REQ_STREAM = 1'b1;

	// Index arithmetic is done at this width before folding into the table.
	localparam int unsigned IDX_W = 17;

	// Result queue: room for two items of two results each.
	localparam int unsigned MAX_RESULTS = 2;
	localparam int unsigned RES_DEPTH   = 4;
	localparam int unsigned RES_PTR_W   = 2;
	localparam int unsigned RES_CNT_W   = 3;

	// What an accepted item leaves for the result stage.
	typedef enum logic [1:0] {
		KIND_NONE,
		KIND_SINGLE,
		KIND_PAIR_PASS,
		KIND_PAIR_XLAT
	} kind_t;

	// One result as it leaves the block.
	typedef struct packed {
		logic [7:0] out_byte;
		logic       translated;
		logic       run_last;
	} result_t;

	function automatic logic gb_lead_ok(input logic [7:0] b);
		return (b >= 8'hA1 && b <= 8'hA9) || (b >= 8'hB0 && b <= 8'hF7);
	endfunction

	function automatic logic big5_lead_ok(input logic [7:0] b);
		return b >= 8'hA1 && b <= 8'hF9;
	endfunction

	function automatic logic lead_ok(input logic dir, input logic [7:0] b);
		return (dir == DIR_BIG5_TO_GB) ? big5_lead_ok(b) : gb_lead_ok(b);
	endfunction

endpackage

`default_nettype wire

>>> rtl/gbbt_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module gbbt_ram #(
	parameter int unsigned WIDTH = 16,
	parameter int unsigned DEPTH = 32768
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

>>> rtl/gbbt_pair_index.sv
// Lead/trail pair check and table word index for both directions.
// Depends on gbbt_pkg.
`default_nettype none

module gbbt_pair_index #(
	parameter int unsigned TABLE_WORDS = gbbt_pkg::TABLE_WORDS_DEF
) (
	input  wire logic                           direction,
	input  wire logic [14:0]                    gb_rows_base,
	input  wire logic [7:0]                     lead,
	input  wire logic [7:0]                     trail,
	output logic                                pair_ok,
	output logic      [$clog2(TABLE_WORDS)-1:0] pair_idx
);
	import gbbt_pkg::*;

	localparam int unsigned AW = $clog2(TABLE_WORDS);
	localparam logic [IDX_W-1:0] TW = IDX_W'(TABLE_WORDS);

	logic [6:0]       gb_row;
	logic [6:0]       gb_col;
	logic [13:0]      gb_row_off;
	logic [IDX_W-1:0] gb_sum;
	logic [IDX_W-1:0] gb_idx;
	logic             gb_ok;
	logic [6:0]       b5_row;
	logic [7:0]       b5_col;
	logic [13:0]      b5_row_off;
	logic [IDX_W-1:0] b5_idx;
	logic             b5_trail_lo;
	logic             b5_trail_hi;
	logic             b5_ok;

	// GB2312: two lead ranges map onto consecutive rows of 94 cells.
	always_comb begin
		gb_row     = (lead <= 8'hA9) ? 7'(lead - 8'hA1) : 7'(lead - 8'hB0 + 8'd9);
		gb_col     = 7'(trail - 8'hA1);
		gb_row_off = 14'(gb_row) * 14'd94;
		gb_sum     = IDX_W'(gb_rows_base) + IDX_W'(gb_row_off) + IDX_W'(gb_col);
		// The sum stays below twice the table size, so one fold suffices.
		gb_idx     = (gb_sum >= TW) ? (gb_sum - TW) : gb_sum;
		gb_ok      = gb_lead_ok(lead) && trail >= 8'hA1 && trail <= 8'hFE;
	end

	// Big5: 157 columns per lead, low trails first, then high trails.
	always_comb begin
		b5_trail_lo = trail >= 8'h40 && trail <= 8'h7E;
		b5_trail_hi = trail >= 8'hA1 && trail <= 8'hFE;
		b5_row      = 7'(lead - 8'hA1);
		b5_col      = b5_trail_lo ? (trail - 8'h40) : (trail - 8'hA1 + 8'd63);
		b5_row_off  = 14'(b5_row) * 14'd157;
		b5_idx      = IDX_W'(b5_row_off) + IDX_W'(b5_col);
		b5_ok       = big5_lead_ok(lead) && (b5_trail_lo || b5_trail_hi);
	end

	// Select by direction.
	always_comb begin
		if (direction == DIR_BIG5_TO_GB) begin
			pair_ok  = b5_ok;
			pair_idx = AW'(b5_idx);
		end else begin
			pair_ok  = gb_ok;
			pair_idx = AW'(gb_idx);
		end
	end

endmodule

`default_nettype wire

>>> rtl/gbbt_result_fifo.sv
// Four-entry result queue that takes up to two results per cycle and
// hands out one per transfer. Depends on gbbt_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module gbbt_result_fifo (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic [1:0]                        push_cnt,
	input  wire gbbt_pkg::result_t                 push0,
	input  wire gbbt_pkg::result_t                 push1,
	output logic      [gbbt_pkg::RES_CNT_W-1:0]    count,
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output gbbt_pkg::result_t                      head
);
	import gbbt_pkg::*;

	result_t              mem_q [RES_DEPTH];
	logic [RES_PTR_W-1:0] wr_ptr_q;
	logic [RES_PTR_W-1:0] rd_ptr_q;
	logic [RES_CNT_W-1:0] count_q;
	logic                 pop;

	assign pop       = out_valid && !out_stall;
	assign out_valid = count_q != '0;
	assign head      = mem_q[rd_ptr_q];
	assign count     = count_q;

	// Entry storage; the producer never pushes beyond free space.
	always_ff @(posedge clk) begin
		if (push_cnt != 2'd0) begin
			mem_q[wr_ptr_q] <= push0;
		end
		if (push_cnt == 2'd2) begin
			mem_q[wr_ptr_q + RES_PTR_W'(1)] <= push1;
		end
	end

	// Pointers and occupancy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + RES_PTR_W'(push_cnt);
			rd_ptr_q <= rd_ptr_q + RES_PTR_W'(pop);
			count_q  <= count_q + RES_CNT_W'(push_cnt) - RES_CNT_W'(pop);
		end
	end

	`ASSERT_NEVER(a_fifo_overflow, clk, arst_n, (count_q + RES_CNT_W'(push_cnt)) > (RES_CNT_W'(RES_DEPTH) + RES_CNT_W'(pop)))
	`ASSERT_NEVER(a_fifo_push_range, clk, arst_n, push_cnt == 2'd3)

endmodule

`default_nettype wire

>>> rtl/gb2312_big5_transcoder.sv
// Top level of the GB2312 / Big5 byte-stream transcoder.
// Depends on gbbt_pkg, gbbt_ram, gbbt_pair_index, gbbt_result_fifo.
//
// Usage: the input channel (in_valid/in_stall) carries either a table load
// (req_type 0: table_word is written at table_index, no result) or one
// stream byte (req_type 1). A valid lead byte is held and produces nothing;
// the next stream byte then yields two results, the two table bytes of the
// pair or both bytes unchanged. Other bytes yield one result. The output
// channel (out_valid/out_stall) carries one result per transfer, run_last
// marking the final result of the item that caused it.
// Throughput: one item per cycle while the receiver keeps up; a character
// is a lead item with no result and a trail item with two, so the output
// side, one result per cycle, keeps pace with the input.
// Results pass stage 1 (with the registered table read), then the queue.
// Reset clears the held lead, the result queue and the registers (direction
// 0, GB rows base 13973); the table contents are undefined until loaded.
// When the receiver stalls, results collect in a four-entry queue and
// in_stall rises once the queue, with the results still in stage 1, lacks
// room for what the next item can add (two after a held lead, else one).
// Configuration is to be written through cfg_wr_en/cfg_index/cfg_wdata
// only while idle; this binds the user, the block does not enforce it.
`default_nettype none
`include "assert_macros.svh"

module gb2312_big5_transcoder #(
	parameter int unsigned TABLE_WORDS = gbbt_pkg::TABLE_WORDS_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	// Configuration write port.
	input  wire logic                            cfg_wr_en,
	input  wire logic [0:0]                      cfg_index,
	input  wire logic [gbbt_pkg::CFG_DATA_W-1:0] cfg_wdata,
	// Input channel.
	input  wire logic                            in_valid,
	output logic                                 in_stall,
	input  wire logic                            req_type,
	input  wire logic [14:0]                     table_index,
	input  wire logic [15:0]                     table_word,
	input  wire logic [7:0]                      in_byte,
	input  wire logic                            chunk_end,
	// Output channel.
	output logic                                 out_valid,
	input  wire logic                            out_stall,
	output logic      [7:0]                      out_byte,
	output logic                                 translated,
	output logic                                 run_last
);
	import gbbt_pkg::*;

	localparam int unsigned AW = $clog2(TABLE_WORDS);

	logic                 direction_q;
	logic [14:0]          gb_rows_base_q;
	logic                 lead_held_q;
	logic [7:0]           lead_q;
	kind_t                kind_d;
	kind_t                kind_s1;
	logic [7:0]           lead_s1;
	logic [7:0]           byte_s1;
	logic                 in_xfer;
	logic                 stream_xfer;
	logic                 new_lead;
	logic                 pair_ok;
	logic [AW-1:0]        pair_idx;
	logic                 wr_en;
	logic                 rd_en;
	logic [15:0]          rd_data;
	logic [1:0]           push_cnt;
	result_t              push0;
	result_t              push1;
	result_t              head;
	logic [RES_CNT_W-1:0] fifo_count;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			direction_q    <= DIR_GB_TO_BIG5;
			gb_rows_base_q <= GB_ROWS_BASE_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_DIRECTION:    direction_q    <= cfg_wdata[0];
				REG_GB_ROWS_BASE: gb_rows_base_q <= cfg_wdata[14:0];
				default: ;
			endcase
		end
	end

	// Input transfer and its classification.
	assign in_xfer     = in_valid && !in_stall;
	assign stream_xfer = in_xfer && req_type == REQ_STREAM;
	assign new_lead    = lead_ok(direction_q, in_byte) && !chunk_end;
	assign wr_en       = in_xfer && req_type == REQ_LOAD
	                     && IDX_W'(table_index) < IDX_W'(TABLE_WORDS);
	assign rd_en       = stream_xfer && lead_held_q && pair_ok;

	gbbt_pair_index #(
		.TABLE_WORDS (TABLE_WORDS)
	) u_pair_index (
		.direction    (direction_q),
		.gb_rows_base (gb_rows_base_q),
		.lead         (lead_q),
		.trail        (in_byte),
		.pair_ok      (pair_ok),
		.pair_idx     (pair_idx)
	);

	gbbt_ram #(
		.WIDTH (16),
		.DEPTH (TABLE_WORDS)
	) u_code_table (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (AW'(table_index)),
		.wr_data (table_word),
		.rd_en   (rd_en),
		.rd_addr (pair_idx),
		.rd_data (rd_data)
	);

	// What this transfer leaves for the result stage.
	always_comb begin
		kind_d = KIND_NONE;
		if (stream_xfer) begin
			if (lead_held_q) begin
				kind_d = pair_ok ? KIND_PAIR_XLAT : KIND_PAIR_PASS;
			end else if (!new_lead) begin
				kind_d = KIND_SINGLE;
			end
		end
	end

	// Held lead byte; a load leaves it untouched.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lead_held_q <= 1'b0;
			lead_q      <= '0;
		end else if (stream_xfer) begin
			lead_held_q <= !lead_held_q && new_lead;
			lead_q      <= (!lead_held_q && new_lead) ? in_byte : 8'h00;
		end
	end

	// Stage 1 control, in step with the table read.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_s1 <= KIND_NONE;
		end else begin
			kind_s1 <= kind_d;
		end
	end

	// Stage 1 payload.
	always_ff @(posedge clk) begin
		if (stream_xfer) begin
			lead_s1 <= lead_q;
			byte_s1 <= in_byte;
		end
	end

	// Results of the stage 1 item.
	always_comb begin
		push_cnt = 2'd0;
		push0    = '{out_byte: byte_s1, translated: 1'b0, run_last: 1'b1};
		push1    = '{out_byte: byte_s1, translated: 1'b0, run_last: 1'b1};
		unique case (kind_s1)
			KIND_NONE: begin
				push_cnt = 2'd0;
			end
			KIND_SINGLE: begin
				push_cnt = 2'd1;
			end
			KIND_PAIR_PASS: begin
				push_cnt = 2'd2;
				push0    = '{out_byte: lead_s1, translated: 1'b0, run_last: 1'b0};
			end
			KIND_PAIR_XLAT: begin
				push_cnt = 2'd2;
				push0    = '{out_byte: rd_data[15:8], translated: 1'b1, run_last: 1'b0};
				push1    = '{out_byte: rd_data[7:0], translated: 1'b1, run_last: 1'b1};
			end
			default: begin
				push_cnt = 2'd0;
			end
		endcase
	end

	gbbt_result_fifo u_result_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_cnt  (push_cnt),
		.push0     (push0),
		.push1     (push1),
		.count     (fifo_count),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.head      (head)
	);

	// Accept only when the queue has room for stage 1 plus the most the next
	// item can add: two results after a held lead, at most one otherwise.
	assign in_stall = (fifo_count + RES_CNT_W'(push_cnt))
	                  > (lead_held_q ? RES_CNT_W'(RES_DEPTH - MAX_RESULTS)
	                                 : RES_CNT_W'(RES_DEPTH - 1));

	assign out_byte   = head.out_byte;
	assign translated = head.translated;
	assign run_last   = head.run_last;

	`ASSERT_CLK(a_held_lead_pairs, clk, arst_n, (stream_xfer && lead_held_q) |=> (kind_s1 == KIND_PAIR_PASS || kind_s1 == KIND_PAIR_XLAT))
	`ASSERT_CLK(a_read_means_xlat, clk, arst_n, rd_en |=> (kind_s1 == KIND_PAIR_XLAT))
	`ASSERT_CLK(a_load_keeps_lead, clk, arst_n, (in_xfer && req_type == REQ_LOAD) |=> ($stable(lead_held_q) && kind_s1 == KIND_NONE))

endmodule

`default_nettype wire
